@@ rtl/core/lbs_pkg.sv @@
// Shared constants and types for the linear blend skinning block.
// No dependencies.
`default_nettype none
package lbs_pkg;
    localparam int MaxBones      = 64;
    localparam int ElemsPerBone  = 12;
    localparam int PalDepth      = MaxBones * ElemsPerBone;
    localparam int PalAw         = $clog2(PalDepth);
    localparam int BoneW         = 6;
    localparam int ElemW         = 4;
    localparam int BiasW         = 17;
    localparam logic [BiasW-1:0] BiasOne = 17'd65536;
    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_APPLY  = 1'b1;

    typedef struct packed {
        logic                    mode;
        logic [BoneW-1:0]        bone_index;
        logic [ElemW-1:0]        element;
        logic signed [31:0]      element_value;
        logic signed [31:0]      pos_x;
        logic signed [31:0]      pos_y;
        logic signed [31:0]      pos_z;
        logic signed [31:0]      nrm_x;
        logic signed [31:0]      nrm_y;
        logic signed [31:0]      nrm_z;
        logic [BiasW-1:0]        bias;
        logic                    last_influence;
    } req_t;

    typedef struct packed {
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [31:0] out_nrm_x;
        logic signed [31:0] out_nrm_y;
        logic signed [31:0] out_nrm_z;
    } rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)       return 32'sh7fffffff;
        else if (v < -66'sd2147483648) return 32'sh80000000;
        else                           return v[31:0];
    endfunction
endpackage
`default_nettype wire

@@ rtl/core/lbs_if.sv @@
// Valid/ready channel interface carrying a payload of type T.
// No dependencies; the payload type is given by parameter T.
`default_nettype none
interface lbs_if #(parameter type T = logic) (input wire logic clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/lbs_palette.sv @@
// Bone palette memory: one write port, one read port, registered read data.
// Depends on lbs_pkg.
`default_nettype none
module lbs_palette
    import lbs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               we,
    input  wire logic [PalAw-1:0]   waddr,
    input  wire logic signed [31:0] wdata,
    input  wire logic [PalAw-1:0]   raddr,
    output logic signed [31:0]      rdata
);
    logic signed [31:0] mem [PalDepth];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ rtl/core/linear_blend_skinning.sv @@
// Linear blend skinning top level, Q16.16.
// Palette write: accepted back to back. Influence: the next request is taken back in idle,
// after the read state (twelve words through the single read port, nine multiplied, the
// translation words added), bias-scale and per-component sum-update; a last influence
// adds emit, plus any wait for the sink to take the prior result from the output register.
// Reset (rst_n, async) clears control and sums; the palette is undefined until written.
`default_nettype none
module linear_blend_skinning
    import lbs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    lbs_if.sink       req,
    lbs_if.source     rsp
);
    typedef enum logic [2:0] {S_IDLE, S_READ, S_ROW, S_SCALE, S_ADD, S_EMIT} state_t;

    state_t             state_reg;
    req_t               item_reg;
    logic [3:0]         idx_reg;      // element being read
    logic [3:0]         cnt_reg;      // element whose data is in rdata
    logic               rvld_reg;
    logic signed [49:0] prow_reg [3];
    logic signed [49:0] nrow_reg [3];
    logic signed [63:0] psum_reg [3];
    logic signed [63:0] nsum_reg [3];
    logic signed [48:0] pc_reg [3];
    logic signed [48:0] nc_reg [3];
    logic [1:0]         sc_reg;
    logic               out_valid_reg;
    rsp_t               out_reg;

    logic               bone_ok;
    logic [PalAw-1:0]   base;
    logic signed [31:0] rdata;
    logic               accept;
    logic               pal_we;

    assign bone_ok = {2'b0, item_reg.bone_index} < 8'(MaxBones);
    assign base    = PalAw'(item_reg.bone_index) * PalAw'(ElemsPerBone);
    assign accept  = req.valid && req.ready;
    // A held result stalls only the emit step; requests are taken only in the idle state.
    assign req.ready = (state_reg == S_IDLE);
    assign pal_we  = accept && req.data.mode == MODE_WRITE
                     && {2'b0, req.data.bone_index} < 8'(MaxBones)
                     && req.data.element < 4'(ElemsPerBone);

    lbs_palette u_pal (
        .clk   (clk),
        .we    (pal_we),
        .waddr (PalAw'(req.data.bone_index) * PalAw'(ElemsPerBone)
                + PalAw'(req.data.element)),
        .wdata (req.data.element_value),
        .raddr (base + PalAw'(idx_reg)),
        .rdata (rdata)
    );

    // Per-read product: element times the matching vector component.
    logic signed [31:0] m;
    logic [1:0]         row, col;
    logic signed [31:0] pv, nv;
    logic signed [63:0] pp, np;
    assign m   = bone_ok ? rdata : 32'sd0;
    assign row = cnt_reg[3:2];
    assign col = cnt_reg[1:0];
    always_comb
    begin
        case (col)
            2'd0:    begin pv = item_reg.pos_x; nv = item_reg.nrm_x; end
            2'd1:    begin pv = item_reg.pos_y; nv = item_reg.nrm_y; end
            default: begin pv = item_reg.pos_z; nv = item_reg.nrm_z; end
        endcase
    end
    assign pp = m * pv;
    assign np = m * nv;

    logic [16:0] bias_c;
    assign bias_c = item_reg.bias > BiasOne ? BiasOne : item_reg.bias;

    logic signed [64:0] pt, nt;
    always_comb
    begin
        pt = 65'(psum_reg[sc_reg]) + 65'(pc_reg[sc_reg]);
        nt = 65'(nsum_reg[sc_reg]) + 65'(nc_reg[sc_reg]);
    end

    function automatic logic signed [63:0] sat64(input logic signed [64:0] v);
        if (v[64] != v[63]) return v[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return v[63:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            rvld_reg      <= 1'b0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            sc_reg        <= '0;
            for (int i = 0; i < 3; i++)
            begin
                psum_reg[i] <= '0;
                nsum_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && rsp.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && req.data.mode == MODE_APPLY)
                    begin
                        item_reg  <= req.data;
                        idx_reg   <= '0;
                        rvld_reg  <= 1'b0;
                        state_reg <= S_READ;
                        for (int i = 0; i < 3; i++)
                        begin
                            prow_reg[i] <= '0;
                            nrow_reg[i] <= '0;
                        end
                    end
                end
                S_READ:
                begin
                    // Issue one read per cycle; consume its data in the next cycle.
                    if (idx_reg < 4'd12)
                        idx_reg <= idx_reg + 4'd1;
                    rvld_reg <= idx_reg < 4'd12;
                    cnt_reg  <= idx_reg;
                    if (rvld_reg)
                    begin
                        if (col == 2'd3)
                            prow_reg[row] <= prow_reg[row] + 50'(m);
                        else
                        begin
                            prow_reg[row] <= prow_reg[row] + 50'(pp >>> 16);
                            nrow_reg[row] <= nrow_reg[row] + 50'(np >>> 16);
                        end
                    end
                    if (!rvld_reg && idx_reg == 4'd12)
                    begin
                        sc_reg    <= '0;
                        state_reg <= S_SCALE;
                    end
                end
                S_SCALE:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        pc_reg[i] <= 49'((sat32(66'(prow_reg[i])) * $signed({1'b0, bias_c}))
                                         >>> 16);
                        nc_reg[i] <= 49'((sat32(66'(nrow_reg[i])) * $signed({1'b0, bias_c}))
                                         >>> 16);
                    end
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    psum_reg[sc_reg] <= sat64(pt);
                    nsum_reg[sc_reg] <= sat64(nt);
                    if (sc_reg == 2'd2)
                        state_reg <= item_reg.last_influence ? S_EMIT : S_IDLE;
                    else
                        sc_reg <= sc_reg + 2'd1;
                end
                S_EMIT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_reg.out_pos_x <= sat32(66'(psum_reg[0]));
                        out_reg.out_pos_y <= sat32(66'(psum_reg[1]));
                        out_reg.out_pos_z <= sat32(66'(psum_reg[2]));
                        out_reg.out_nrm_x <= sat32(66'(nsum_reg[0]));
                        out_reg.out_nrm_y <= sat32(66'(nsum_reg[1]));
                        out_reg.out_nrm_z <= sat32(66'(nsum_reg[2]));
                        out_valid_reg <= 1'b1;
                        for (int i = 0; i < 3; i++)
                        begin
                            psum_reg[i] <= '0;
                            nsum_reg[i] <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;
endmodule
`default_nettype wire
